// ----- sv/spfg_pkg.sv -----
package spfg_pkg;

    // Field widths fixed by the interface
    localparam int WIDTH_W   = 12;
    localparam int THRESH_W  = 8;
    localparam int SPACING_W = 10;
    localparam int MASK_W    = 8;
    localparam int CHAN_W    = 3;
    localparam int TIME_W    = 16;
    localparam int RANK_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    // Register reset values
    localparam logic [WIDTH_W-1:0]   MIN_RESET     = 12'd1000;
    localparam logic [WIDTH_W-1:0]   MAX_RESET     = 12'd2000;
    localparam logic [THRESH_W-1:0]  THRESH_RESET  = 8'd4;
    localparam logic [SPACING_W-1:0] SPACING_RESET = 10'd50;
    localparam logic [MASK_W-1:0]    ENABLE_RESET  = 8'hFF;
    localparam logic [WIDTH_W-1:0]   WIDTH_RESET   = 12'd1500;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd4;

    // Action codes
    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // Shared unit operations
    localparam logic [1:0] OP_LT      = 2'd0;
    localparam logic [1:0] OP_ABSDIFF = 2'd1;
    localparam logic [1:0] OP_WINDOW  = 2'd2;

    typedef struct packed {
        logic [WIDTH_W-1:0]   min_width;
        logic [WIDTH_W-1:0]   max_width;
        logic [THRESH_W-1:0]  noise_threshold;
        logic [SPACING_W-1:0] edge_spacing;
        logic [MASK_W-1:0]    channel_enable;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           op;
        logic [TIME_W-1:0]    a;
        logic [TIME_W-1:0]    b;
        logic [RANK_W-1:0]    rank;
        logic [SPACING_W-1:0] spacing;
    } alu_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] res;
        logic              lt;
        logic              ge;
    } alu_rsp_t;

endpackage

// ----- sv/spfg_cfg.sv -----
module spfg_cfg
    import spfg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_DAT_W-1:0] wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    // Write one register per transfer; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_width       <= MIN_RESET;
            cfg_reg.max_width       <= MAX_RESET;
            cfg_reg.noise_threshold <= THRESH_RESET;
            cfg_reg.edge_spacing    <= SPACING_RESET;
            cfg_reg.channel_enable  <= ENABLE_RESET;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_MIN_WIDTH: cfg_reg.min_width       <= wr_data[WIDTH_W-1:0];
                REG_MAX_WIDTH: cfg_reg.max_width       <= wr_data[WIDTH_W-1:0];
                REG_THRESHOLD: cfg_reg.noise_threshold <= wr_data[THRESH_W-1:0];
                REG_SPACING:   cfg_reg.edge_spacing    <= wr_data[SPACING_W-1:0];
                REG_ENABLE:    cfg_reg.channel_enable  <= wr_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/spfg_alu.sv -----
module spfg_alu
    import spfg_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [12:0] base;
    logic [13:0] pulse_end;

    // Rising edge offset and falling edge of one channel in the frame
    assign base      = 13'(req.rank) * 13'(req.spacing);
    assign pulse_end = {1'b0, base} + {2'b00, req.b[WIDTH_W-1:0]};

    always_comb begin
        rsp.res = '0;
        rsp.lt  = 1'b0;
        rsp.ge  = 1'b0;
        unique case (req.op)
            OP_LT: begin
                rsp.lt = req.a < req.b;
            end
            OP_ABSDIFF: begin
                rsp.res = (req.a >= req.b) ? (req.a - req.b) : (req.b - req.a);
            end
            OP_WINDOW: begin
                rsp.res = {2'b00, pulse_end};
                rsp.lt  = req.a < {2'b00, pulse_end};
                rsp.ge  = req.a >= {3'b000, base};
            end
            default: ;
        endcase
    end

endmodule

// ----- sv/servo_pulse_frame_generator.sv -----
// Channel  Direction  Transfer when        Content
// s_       in         s_valid & s_ready    s_action, s_channel, s_width
// m_       out        m_valid & m_ready    m_pin_levels, m_frame_active,
//                                          m_width_readback, m_set_rejected
// cfg_     in         cfg_valid & cfg_ready cfg_index, cfg_data (always ready)
//
// One item at a time, N = min(CHANNELS, 8) live channels, all work on one
// shared compare/multiply-add unit. A Set on a live channel steps through
// clamp high, clamp low, difference and threshold. Start runs one load and N
// compares per channel rank, then one window check per channel. A tick, or
// any item during a frame, runs one window check per channel. A finished
// result waits in the output register while the next item is taken; the
// sequencer holds its last step only if that register is still full. Reset
// is synchronous and restores every width to 1500.
module servo_pulse_frame_generator
    import spfg_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_action,
    input  logic [CHAN_W-1:0]    s_channel,
    input  logic [WIDTH_W-1:0]   s_width,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [MASK_W-1:0]    m_pin_levels,
    output logic                 m_frame_active,
    output logic [WIDTH_W-1:0]   m_width_readback,
    output logic                 m_set_rejected,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int LIVE  = (CHANNELS < 8) ? CHANNELS : 8;
    localparam int IDX_W = (LIVE > 1) ? $clog2(LIVE) : 1;
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(LIVE - 1);
    localparam logic [MASK_W-1:0] LIVE_MASK = MASK_W'((1 << LIVE) - 1);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_CLAMP_HI  = 4'd1;
    localparam logic [3:0] ST_CLAMP_LO  = 4'd2;
    localparam logic [3:0] ST_DIFF      = 4'd3;
    localparam logic [3:0] ST_THRESH    = 4'd4;
    localparam logic [3:0] ST_RANK_LOAD = 4'd5;
    localparam logic [3:0] ST_RANK_CMP  = 4'd6;
    localparam logic [3:0] ST_EVAL      = 4'd7;
    localparam logic [3:0] ST_DONE      = 4'd8;

    cfg_t     cfg;
    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic [3:0]          state_reg, state_next;
    logic [IDX_W-1:0]    k_reg;
    logic [IDX_W-1:0]    j_reg;
    logic [CHAN_W-1:0]   ch_reg;
    logic [WIDTH_W-1:0]  req_reg;
    logic [TIME_W-1:0]   diff_reg;
    logic [WIDTH_W+RANK_W-1:0] key_reg;
    logic [RANK_W-1:0]   rank_acc_reg, rank_acc_next;
    logic [MASK_W-1:0]   lv_reg, lv_next;
    logic                run_acc_reg, run_acc_next;
    logic                upd_run_reg;
    logic                rej_reg;
    logic                running_reg;
    logic [MASK_W-1:0]   members_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [WIDTH_W-1:0]  width_reg [LIVE];
    logic [RANK_W-1:0]   rank_reg [LIVE];

    logic [IDX_W-1:0]    rd_addr;
    logic [WIDTH_W-1:0]  rd_width;
    logic                ch_ok;
    logic                out_free;
    logic                in_xfer;

    logic                m_valid_reg;
    logic [MASK_W-1:0]   m_levels_reg;
    logic                m_active_reg;
    logic [WIDTH_W-1:0]  m_readback_reg;
    logic                m_rejected_reg;

    spfg_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    spfg_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign ch_ok     = int'(ch_reg) < LIVE;

    // Single width read port, steered by the sequencer
    always_comb begin
        unique case (state_reg) inside
            ST_RANK_LOAD, ST_EVAL: rd_addr = k_reg;
            ST_RANK_CMP:           rd_addr = j_reg;
            default:               rd_addr = ch_reg[IDX_W-1:0];
        endcase
    end
    assign rd_width = width_reg[rd_addr];

    // Drive the shared unit for the current step
    always_comb begin
        alu_req         = '0;
        alu_req.spacing = cfg.edge_spacing;
        unique case (state_reg)
            ST_CLAMP_HI: begin
                alu_req.op = OP_LT;
                alu_req.a  = {4'b0, cfg.max_width};
                alu_req.b  = {4'b0, req_reg};
            end
            ST_CLAMP_LO: begin
                alu_req.op = OP_LT;
                alu_req.a  = {4'b0, req_reg};
                alu_req.b  = {4'b0, cfg.min_width};
            end
            ST_DIFF: begin
                alu_req.op = OP_ABSDIFF;
                alu_req.a  = {4'b0, req_reg};
                alu_req.b  = {4'b0, rd_width};
            end
            ST_THRESH: begin
                alu_req.op = OP_LT;
                alu_req.a  = {8'b0, cfg.noise_threshold};
                alu_req.b  = diff_reg;
            end
            ST_RANK_CMP: begin
                // width then index: ties go to the lower channel
                alu_req.op = OP_LT;
                alu_req.a  = {1'b0, rd_width, RANK_W'(j_reg)};
                alu_req.b  = {1'b0, key_reg};
            end
            ST_EVAL: begin
                alu_req.op   = OP_WINDOW;
                alu_req.a    = time_reg;
                alu_req.b    = {4'b0, rd_width};
                alu_req.rank = rank_reg[k_reg];
            end
            default: ;
        endcase
    end

    // Accumulators for ranking and level evaluation
    always_comb begin
        rank_acc_next = rank_acc_reg;
        if (members_reg[k_reg] && members_reg[j_reg] && alu_rsp.lt) begin
            rank_acc_next = rank_acc_reg + RANK_W'(1);
        end
        run_acc_next = run_acc_reg;
        lv_next      = lv_reg;
        if (members_reg[k_reg] && alu_rsp.lt) begin
            run_acc_next = 1'b1;
            if (alu_rsp.ge) begin
                lv_next[k_reg] = 1'b1;
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = running_reg ? ST_EVAL : ST_DONE;
                    if (s_action == ACT_SET && !running_reg && int'(s_channel) < LIVE) begin
                        state_next = ST_CLAMP_HI;
                    end else if (s_action == ACT_START && !running_reg) begin
                        state_next = ST_RANK_LOAD;
                    end
                end
            end
            ST_CLAMP_HI:  state_next = ST_CLAMP_LO;
            ST_CLAMP_LO:  state_next = ST_DIFF;
            ST_DIFF:      state_next = ST_THRESH;
            ST_THRESH:    state_next = ST_DONE;
            ST_RANK_LOAD: state_next = ST_RANK_CMP;
            ST_RANK_CMP: begin
                if (j_reg == LAST_IDX) begin
                    state_next = (k_reg == LAST_IDX) ? ST_EVAL : ST_RANK_LOAD;
                end
            end
            ST_EVAL: begin
                if (k_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state and channel stores
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            j_reg       <= '0;
            running_reg <= 1'b0;
            members_reg <= '0;
            time_reg    <= '0;
            for (int i = 0; i < LIVE; i++) begin
                width_reg[i] <= WIDTH_RESET;
                rank_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    k_reg <= '0;
                    if (in_xfer) begin
                        if (s_action == ACT_START && !running_reg) begin
                            members_reg <= cfg.channel_enable & LIVE_MASK;
                            time_reg    <= '0;
                        end else if (s_action == ACT_TICK && running_reg) begin
                            if (time_reg != '1) begin
                                time_reg <= time_reg + TIME_W'(1);
                            end
                        end
                    end
                end
                ST_THRESH: begin
                    if (alu_rsp.lt) begin
                        width_reg[ch_reg[IDX_W-1:0]] <= req_reg;
                    end
                end
                ST_RANK_LOAD: begin
                    j_reg <= '0;
                end
                ST_RANK_CMP: begin
                    j_reg <= j_reg + IDX_W'(1);
                    if (j_reg == LAST_IDX) begin
                        rank_reg[k_reg] <= rank_acc_next;
                        k_reg           <= (k_reg == LAST_IDX) ? '0 : k_reg + IDX_W'(1);
                    end
                end
                ST_EVAL: begin
                    k_reg <= k_reg + IDX_W'(1);
                    if (k_reg == LAST_IDX && upd_run_reg) begin
                        running_reg <= run_acc_next;
                    end
                end
                default: ;
            endcase
        end
    end

    // Per-item working registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    ch_reg      <= s_channel;
                    req_reg     <= s_width;
                    rej_reg     <= (s_action == ACT_SET) && running_reg;
                    upd_run_reg <= (s_action == ACT_TICK) ||
                                   ((s_action == ACT_START) && !running_reg);
                    lv_reg      <= '0;
                    run_acc_reg <= 1'b0;
                end
            end
            ST_CLAMP_HI: begin
                if (alu_rsp.lt) begin
                    req_reg <= cfg.max_width;
                end
            end
            ST_CLAMP_LO: begin
                if (alu_rsp.lt) begin
                    req_reg <= cfg.min_width;
                end
            end
            ST_DIFF: begin
                diff_reg <= alu_rsp.res;
            end
            ST_RANK_LOAD: begin
                key_reg      <= {rd_width, RANK_W'(k_reg)};
                rank_acc_reg <= '0;
            end
            ST_RANK_CMP: begin
                rank_acc_reg <= rank_acc_next;
            end
            ST_EVAL: begin
                lv_reg      <= lv_next;
                run_acc_reg <= run_acc_next;
            end
            default: ;
        endcase
    end

    // Output register: hold the result until its transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_levels_reg   <= lv_reg;
            m_active_reg   <= running_reg;
            m_readback_reg <= ch_ok ? rd_width : '0;
            m_rejected_reg <= rej_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pin_levels     = m_levels_reg;
    assign m_frame_active   = m_active_reg;
    assign m_width_readback = m_readback_reg;
    assign m_set_rejected   = m_rejected_reg;

endmodule

// ----- tb/tb_servo_pulse_frame_generator.sv -----
`timescale 1ns / 1ps

module tb_servo_pulse_frame_generator;
    import spfg_pkg::*;

    localparam int        LIVE        = 8;
    localparam int        RAND_ITEMS  = 1550;
    localparam int        CFG_PAUSE   = 16;
    localparam int        TAIL_CYCLES = 100;
    localparam int        HOLD_CYCLES = 400;
    localparam int        LIMIT       = 1000000;
    localparam int        TIME_MAX    = 65535;
    localparam logic [1:0] ACT_STATUS = 2'd3;

    typedef struct packed {
        logic [MASK_W-1:0]  pins;
        logic               active;
        logic [WIDTH_W-1:0] readback;
        logic               rejected;
    } servo_status_t;

    typedef enum logic [1:0] {ROW_ITEM, ROW_EXPECT, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [1:0]           act;
        logic [CHAN_W-1:0]    ch;
        logic [CFG_DAT_W-1:0] value;
        servo_status_t        want;
    } stim_row_t;

    // Directed walk: clamp corners, thresholds, empty start, a short frame
    // with spacing and enable rewritten mid frame, and a zero-width start.
    localparam stim_row_t DIRECTED [36] = '{
        '{ROW_EXPECT, '0, ACT_TICK,   3'd0, 12'd0,    '{8'h00, 1'b0, 12'd1500, 1'b0}},
        '{ROW_EXPECT, '0, ACT_STATUS, 3'd7, 12'hFFF,  '{8'h00, 1'b0, 12'd1500, 1'b0}},
        '{ROW_EXPECT, '0, ACT_SET,    3'd0, 12'd0,    '{8'h00, 1'b0, 12'd1000, 1'b0}},
        '{ROW_EXPECT, '0, ACT_SET,    3'd1, 12'hFFF,  '{8'h00, 1'b0, 12'd2000, 1'b0}},
        '{ROW_EXPECT, '0, ACT_SET,    3'd2, 12'd1504, '{8'h00, 1'b0, 12'd1500, 1'b0}},
        '{ROW_EXPECT, '0, ACT_SET,    3'd2, 12'd1505, '{8'h00, 1'b0, 12'd1505, 1'b0}},
        '{ROW_CFG, REG_MIN_WIDTH, '0, '0, 12'd3000, '0},
        '{ROW_EXPECT, '0, ACT_SET,    3'd3, 12'd100,  '{8'h00, 1'b0, 12'd3000, 1'b0}},
        '{ROW_CFG, REG_MIN_WIDTH, '0, '0, 12'd0,    '0},
        '{ROW_CFG, REG_MAX_WIDTH, '0, '0, 12'd4095, '0},
        '{ROW_CFG, REG_THRESHOLD, '0, '0, 12'd255,  '0},
        '{ROW_EXPECT, '0, ACT_SET,    3'd4, 12'd4095, '{8'h00, 1'b0, 12'd4095, 1'b0}},
        '{ROW_EXPECT, '0, ACT_SET,    3'd5, 12'd0,    '{8'h00, 1'b0, 12'd0,    1'b0}},
        '{ROW_CFG, REG_THRESHOLD, '0, '0, 12'd0,    '0},
        '{ROW_EXPECT, '0, ACT_SET,    3'd6, 12'd1501, '{8'h00, 1'b0, 12'd1501, 1'b0}},
        '{ROW_CFG, REG_ENABLE,    '0, '0, 12'd0,    '0},
        '{ROW_CFG, REG_SPACING,   '0, '0, 12'd1023, '0},
        '{ROW_EXPECT, '0, ACT_START,  3'd6, 12'd0,    '{8'h00, 1'b0, 12'd1501, 1'b0}},
        '{ROW_CFG, REG_SPACING,   '0, '0, 12'd1,    '0},
        '{ROW_EXPECT, '0, ACT_SET,    3'd0, 12'd2,    '{8'h00, 1'b0, 12'd2,    1'b0}},
        '{ROW_EXPECT, '0, ACT_SET,    3'd7, 12'd2,    '{8'h00, 1'b0, 12'd2,    1'b0}},
        '{ROW_CFG, REG_ENABLE,    '0, '0, 12'h0A1,  '0},
        '{ROW_ITEM, '0, ACT_START,  3'd5, 12'd0,    '0},
        '{ROW_ITEM, '0, ACT_START,  3'd0, 12'd0,    '0},
        '{ROW_ITEM, '0, ACT_SET,    3'd1, 12'd7,    '0},
        '{ROW_ITEM, '0, ACT_TICK,   3'd7, 12'd0,    '0},
        '{ROW_CFG, REG_SPACING,   '0, '0, 12'd2,    '0},
        '{ROW_CFG, REG_ENABLE,    '0, '0, 12'd0,    '0},
        '{ROW_ITEM, '0, ACT_TICK,   3'd0, 12'd0,    '0},
        '{ROW_ITEM, '0, ACT_TICK,   3'd7, 12'd0,    '0},
        '{ROW_ITEM, '0, ACT_TICK,   3'd5, 12'd0,    '0},
        '{ROW_ITEM, '0, ACT_TICK,   3'd3, 12'd0,    '0},
        '{ROW_ITEM, '0, ACT_TICK,   3'd1, 12'd0,    '0},
        '{ROW_ITEM, '0, ACT_TICK,   3'd6, 12'd0,    '0},
        '{ROW_CFG, REG_ENABLE,    '0, '0, 12'h020,  '0},
        '{ROW_ITEM, '0, ACT_START,  3'd5, 12'd0,    '0}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_action = '0;
    logic [CHAN_W-1:0]    s_channel = '0;
    logic [WIDTH_W-1:0]   s_width = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [MASK_W-1:0]    m_pin_levels;
    logic                 m_frame_active;
    logic [WIDTH_W-1:0]   m_width_readback;
    logic                 m_set_rejected;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    // Shadow copy of the generator state and its registers
    cfg_t               servo_cfg;
    logic [WIDTH_W-1:0] servo_width [LIVE];
    logic [RANK_W-1:0]  servo_rank [LIVE];
    int                 frame_clock;
    bit                 frame_on;
    logic [MASK_W-1:0]  frame_set;

    servo_status_t status_due [$];
    int            sent = 0;
    int            errors = 0;
    int            cycle_count = 0;
    int            hold_left = 0;
    bit            hold_req = 1'b0;
    bit            hold_used = 1'b0;
    bit            calm = 1'b0;

    servo_pulse_frame_generator dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_channel        (s_channel),
        .s_width          (s_width),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pin_levels     (m_pin_levels),
        .m_frame_active   (m_frame_active),
        .m_width_readback (m_width_readback),
        .m_set_rejected   (m_set_rejected),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pulse_end(input int k);
        return int'(servo_rank[k]) * int'(servo_cfg.edge_spacing) + int'(servo_width[k]);
    endfunction

    function automatic bit any_pulse_left();
        int k;
        for (k = 0; k < LIVE; k++) begin
            if (frame_set[k] && frame_clock < pulse_end(k)) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [MASK_W-1:0] lit_pins();
        logic [MASK_W-1:0] lv;
        int                k;
        lv = '0;
        for (k = 0; k < LIVE; k++) begin
            if (frame_set[k] && frame_on &&
                frame_clock >= int'(servo_rank[k]) * int'(servo_cfg.edge_spacing) &&
                frame_clock < pulse_end(k)) begin
                lv[k] = 1'b1;
            end
        end
        return lv;
    endfunction

    // Advance the shadow state by one item and return the status it reports
    function automatic servo_status_t servo_status_after(input logic [1:0] act,
                                                         input logic [CHAN_W-1:0] ch,
                                                         input logic [WIDTH_W-1:0] req);
        servo_status_t st;
        logic [WIDTH_W-1:0] lim;
        int diff;
        int k;
        int j;
        int rk;
        st = '0;
        case (act)
            ACT_SET: begin
                if (frame_on) begin
                    st.rejected = 1'b1;
                end else begin
                    // max first, then min: crossed bounds end at min
                    lim = req;
                    if (lim > servo_cfg.max_width) lim = servo_cfg.max_width;
                    if (lim < servo_cfg.min_width) lim = servo_cfg.min_width;
                    diff = (lim > servo_width[ch]) ? int'(lim) - int'(servo_width[ch])
                                                   : int'(servo_width[ch]) - int'(lim);
                    if (diff > int'(servo_cfg.noise_threshold)) servo_width[ch] = lim;
                end
            end
            ACT_START: begin
                if (!frame_on) begin
                    frame_set = servo_cfg.channel_enable;
                    for (k = 0; k < LIVE; k++) begin
                        rk = 0;
                        if (frame_set[k]) begin
                            for (j = 0; j < LIVE; j++) begin
                                if (j != k && frame_set[j] &&
                                    (servo_width[j] < servo_width[k] ||
                                     (servo_width[j] == servo_width[k] && j < k))) begin
                                    rk++;
                                end
                            end
                        end
                        servo_rank[k] = RANK_W'(rk);
                    end
                    frame_clock = 0;
                    frame_on = any_pulse_left();
                end
            end
            ACT_TICK: begin
                if (frame_on) begin
                    if (frame_clock < TIME_MAX) frame_clock++;
                    frame_on = any_pulse_left();
                end
            end
            default: ;
        endcase
        st.readback = servo_width[ch];
        st.pins     = lit_pins();
        st.active   = frame_on;
        return st;
    endfunction

    function automatic logic [WIDTH_W-1:0] pick_width();
        if ($urandom_range(0, 3) == 0) return WIDTH_W'($urandom);
        return WIDTH_W'($urandom_range(0, 70));
    endfunction

    // Offer one item, hold it until the transfer, then queue its status
    task automatic send_item(input logic [1:0] act, input logic [CHAN_W-1:0] ch,
                             input logic [WIDTH_W-1:0] w, input bit typed = 1'b0,
                             input servo_status_t want = '0);
        servo_status_t next;
        if (!calm && $urandom_range(0, 99) < 24) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 24);
        end
        s_valid   <= 1'b1;
        s_action  <= act;
        s_channel <= ch;
        s_width   <= w;
        do @(posedge aclk); while (!(s_valid && s_ready));
        next = servo_status_after(act, ch, w);
        status_due.push_back(typed ? want : next);
        sent++;
    endtask

    // Write one register once every queued status has come back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        s_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
        repeat (CFG_PAUSE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            REG_MIN_WIDTH: servo_cfg.min_width       = data[WIDTH_W-1:0];
            REG_MAX_WIDTH: servo_cfg.max_width       = data[WIDTH_W-1:0];
            REG_THRESHOLD: servo_cfg.noise_threshold = data[THRESH_W-1:0];
            REG_SPACING:   servo_cfg.edge_spacing    = data[SPACING_W-1:0];
            REG_ENABLE:    servo_cfg.channel_enable  = data[MASK_W-1:0];
            default: ;
        endcase
    endtask

    // Pick a new random setting, kept small so frames stay short
    task automatic retune();
        int r;
        r = $urandom_range(0, 5);
        write_reg(REG_MIN_WIDTH, (r == 0) ? 12'd0 : CFG_DAT_W'($urandom_range(0, 30)));
        r = $urandom_range(0, 5);
        write_reg(REG_MAX_WIDTH, (r == 0) ? 12'd0 : CFG_DAT_W'($urandom_range(10, 60)));
        r = $urandom_range(0, 5);
        write_reg(REG_THRESHOLD, (r == 0) ? 12'd255 :
                                 (r == 1) ? 12'd0 : CFG_DAT_W'($urandom_range(0, 6)));
        write_reg(REG_SPACING, CFG_DAT_W'($urandom_range(0, 12)));
        r = $urandom_range(0, 5);
        write_reg(REG_ENABLE, (r == 0) ? 12'h0FF :
                              (r == 1) ? 12'h000 : CFG_DAT_W'($urandom_range(0, 255)));
    endtask

    // Result channel: random stalls, one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 24);
        end
    end

    task note_error(input string what);
        errors++;
        if (errors <= 10) $display("ERROR at cycle %0d: %s", cycle_count, what);
    endtask

    // Check each result transfer against the oldest queued status
    always @(posedge aclk) begin
        servo_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (status_due.size() == 0) begin
                note_error("result transfer with no status queued");
            end else begin
                want = status_due.pop_front();
                if (m_pin_levels !== want.pins || m_frame_active !== want.active ||
                    m_width_readback !== want.readback ||
                    m_set_rejected !== want.rejected) begin
                    note_error($sformatf({"expected pins %02h active %0d width %0d ",
                                          "rejected %0d, got %02h %0d %0d %0d"},
                                         want.pins, want.active, want.readback,
                                         want.rejected, m_pin_levels, m_frame_active,
                                         m_width_readback, m_set_rejected));
                end
            end
        end
    end

    initial begin
        int k;
        int base;
        int r;
        int cut;
        int ticks;
        int next_phase;

        // Shadow state after reset
        servo_cfg = '{MIN_RESET, MAX_RESET, THRESH_RESET, SPACING_RESET, ENABLE_RESET};
        for (k = 0; k < LIVE; k++) begin
            servo_width[k] = WIDTH_RESET;
            servo_rank[k]  = '0;
        end
        frame_clock = 0;
        frame_on    = 1'b0;
        frame_set   = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table
        foreach (DIRECTED[i]) begin
            case (DIRECTED[i].kind)
                ROW_CFG:    write_reg(DIRECTED[i].reg_idx, DIRECTED[i].value);
                ROW_EXPECT: send_item(DIRECTED[i].act, DIRECTED[i].ch,
                                      DIRECTED[i].value, 1'b1, DIRECTED[i].want);
                default:    send_item(DIRECTED[i].act, DIRECTED[i].ch, DIRECTED[i].value);
            endcase
        end

        // Bring every channel down to a small width before random frames
        retune();
        for (k = 0; k < LIVE; k++) begin
            send_item(ACT_SET, CHAN_W'(k), WIDTH_W'($urandom_range(0, 60)));
        end

        base       = sent;
        next_phase = sent + $urandom_range(80, 160);
        while (sent - base < RAND_ITEMS) begin
            if (sent >= next_phase) begin
                retune();
                next_phase = sent + $urandom_range(80, 160);
            end
            if (!hold_req && sent - base >= 300) hold_req <= 1'b1;
            calm <= (sent - base >= 700) && (sent - base < 1000);

            r = $urandom_range(0, 9);
            if (r == 0) begin
                // noise: any action, any field values
                repeat ($urandom_range(1, 6)) begin
                    send_item(2'($urandom), CHAN_W'($urandom), WIDTH_W'($urandom));
                end
            end else begin
                // sets, a start, then ticks until the frame drains or is cut short
                repeat ($urandom_range(0, 4)) begin
                    send_item(ACT_SET, CHAN_W'($urandom), pick_width());
                end
                send_item(ACT_START, CHAN_W'($urandom), WIDTH_W'($urandom));
                cut   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : -1;
                ticks = 0;
                while (frame_on && ticks != cut) begin
                    r = $urandom_range(0, 19);
                    if (r == 0) begin
                        send_item(ACT_SET, CHAN_W'($urandom), pick_width());
                    end else if (r == 1) begin
                        send_item(ACT_START, CHAN_W'($urandom), WIDTH_W'($urandom));
                    end else if (r == 2) begin
                        send_item(ACT_STATUS, CHAN_W'($urandom), WIDTH_W'($urandom));
                    end else begin
                        send_item(ACT_TICK, CHAN_W'($urandom), WIDTH_W'($urandom));
                        ticks++;
                    end
                end
                repeat ($urandom_range(0, 2)) begin
                    send_item(ACT_TICK, CHAN_W'($urandom), WIDTH_W'($urandom));
                end
            end
        end

        // Drain and let the block settle
        s_valid <= 1'b0;
        calm    <= 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
